/* hdl/idq_pkg.sv */
package idq_pkg;

  // Request operation codes
  localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [3:0] OP_POP_FRONT  = 4'd2;
  localparam logic [3:0] OP_POP_BACK   = 4'd3;
  localparam logic [3:0] OP_PEEK_FRONT = 4'd4;
  localparam logic [3:0] OP_PEEK_BACK  = 4'd5;
  localparam logic [3:0] OP_READ_INDEX = 4'd6;
  localparam logic [3:0] OP_ERASE      = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;

  // Input beat
  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] payload_in;
    logic [3:0]  position;
  } idq_in_t;

  // Result beat
  typedef struct packed {
    logic [31:0] payload_out;
    logic        succeeded;
    logic [4:0]  entry_count;
    logic        is_empty;
  } idq_out_t;

  // Decoded command kinds handed from front to back
  typedef enum logic [3:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_PEEK_FRONT,
    CMD_PEEK_BACK,
    CMD_READ_INDEX,
    CMD_ERASE,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] payload;
    logic [3:0]  position;
  } idq_cmd_t;

endpackage

/* hdl/indexed_double_ended_queue.sv */
// Bounded double-ended queue of DEPTH payload words held in a ring store.
// Input channel (in_valid/in_ready/in_data) takes one request per beat:
// push or pop at either end, peek at either end, read or erase at an index
// from the front, or clear. Result channel (out_valid/out_ready/out_data)
// returns exactly one beat per request, in request order, with the payload
// read, a success flag, the entry count after the request and an empty flag.
// A front stage decodes requests into a two-entry command queue; the back
// sequencer executes them against the ring store RAM.
// Push, clear and refused requests load the result register directly; pop,
// peek and read first pass through the registered RAM read. The back takes
// one request per cycle for push and clear while the result register is free;
// pop, peek and read hold it in a read state for the registered read of the
// single RAM read port. Erase returns its result right away but keeps the back
// busy while later entries move one slot toward the front, each read then written.
// When out_ready is low, the result register holds its beat; the command
// queue keeps accepting until both entries are full.
// Reset (rst_n low, synchronous) empties the queue and drops queued commands;
// store contents are not cleared and are never read before being written.
module indexed_double_ended_queue
  import idq_pkg::*;
#(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  idq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output idq_out_t out_data
);

  logic     cmd_valid;
  logic     cmd_ready;
  idq_cmd_t cmd;

  idq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  idq_back #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/idq_ram.sv */
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/idq_front.sv */
module idq_front
  import idq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  idq_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output idq_cmd_t cmd
);

  localparam int QDEPTH = 2;

  idq_cmd_t   q_r [QDEPTH];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  idq_cmd_t   dec;
  logic       push, pop;

  // Classify the request code
  always_comb begin
    dec.payload  = in_data.payload_in;
    dec.position = in_data.position;
    case (in_data.operation)
      OP_PUSH_FRONT: dec.kind = CMD_PUSH_FRONT;
      OP_PUSH_BACK:  dec.kind = CMD_PUSH_BACK;
      OP_POP_FRONT:  dec.kind = CMD_POP_FRONT;
      OP_POP_BACK:   dec.kind = CMD_POP_BACK;
      OP_PEEK_FRONT: dec.kind = CMD_PEEK_FRONT;
      OP_PEEK_BACK:  dec.kind = CMD_PEEK_BACK;
      OP_READ_INDEX: dec.kind = CMD_READ_INDEX;
      OP_ERASE:      dec.kind = CMD_ERASE;
      OP_CLEAR:      dec.kind = CMD_CLEAR;
      default:       dec.kind = CMD_NOP;
    endcase
  end

  // Two-entry command queue
  assign in_ready  = (cnt_r != 2'(QDEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

/* hdl/idq_back.sv */
module idq_back
  import idq_pkg::*;
#(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  idq_cmd_t cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output idq_out_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 4) ? CW : 4;
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_t;

  state_t   state_r, state_nxt;
  logic [PW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [PW-1:0] k_r, k_nxt;
  idq_out_t out_r, out_nxt;
  logic     out_valid_r, out_valid_nxt;

  logic                     wr_en, rd_en;
  logic [PW-1:0]            wr_addr, rd_addr;
  logic [PAYLOAD_WIDTH-1:0] wr_data, rd_data;

  logic          out_free, is_full, is_empty_q, pos_ok;
  logic          load, load_ok;
  logic [31:0]   load_payload;
  logic [PW-1:0] front_dec, front_inc, occ_lo, occ_m1_lo, pos_lo, k_inc;
  logic [CW-1:0] occ_m1;
  logic [PW+3:0] pos_ext;
  logic [95:0]   in_word;
  logic [PAYLOAD_WIDTH+31:0] rd_word;
  logic [CW+4:0] cnt_word;

  // Ring slot of an offset from the front entry
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [PW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  // Ring store
  idq_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Width conversions and pointer arithmetic
  assign in_word    = {64'd0, cmd.payload};
  assign wr_data    = (state_r == ST_SHIFT_WR) ? rd_data : in_word[PAYLOAD_WIDTH-1:0];
  assign rd_word    = {32'd0, rd_data};
  assign out_free   = !out_valid_r || out_ready;
  assign is_full    = (occ_r == FULL_CNT);
  assign is_empty_q = (occ_r == '0);
  assign pos_ok     = IW'(cmd.position) < IW'(occ_r);
  assign front_dec  = (front_r == '0) ? LAST_SLOT : front_r - PW'(1);
  assign front_inc  = (front_r == LAST_SLOT) ? '0 : front_r + PW'(1);
  assign occ_lo     = occ_r[PW-1:0];
  assign occ_m1     = occ_r - CW'(1);
  assign occ_m1_lo  = occ_m1[PW-1:0];
  assign pos_ext    = {{PW{1'b0}}, cmd.position};
  assign pos_lo     = pos_ext[PW-1:0];
  assign k_inc      = k_r + PW'(1);

  // Sequencer next state
  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    occ_nxt      = occ_r;
    k_nxt        = k_r;
    cmd_ready    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    load         = 1'b0;
    load_ok      = 1'b0;
    load_payload = 32'd0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            CMD_PUSH_FRONT: begin
              load    = 1'b1;
              load_ok = !is_full;
              if (!is_full) begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                occ_nxt   = occ_r + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              load    = 1'b1;
              load_ok = !is_full;
              if (!is_full) begin
                wr_en   = 1'b1;
                wr_addr = slot_of(front_r, occ_lo);
                occ_nxt = occ_r + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty_q) begin
                load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                front_nxt = front_inc;
                occ_nxt   = occ_m1;
                state_nxt = ST_READ;
              end
            end
            CMD_POP_BACK: begin
              if (is_empty_q) begin
                load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = slot_of(front_r, occ_m1_lo);
                occ_nxt   = occ_m1;
                state_nxt = ST_READ;
              end
            end
            CMD_PEEK_FRONT: begin
              if (is_empty_q) begin
                load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                state_nxt = ST_READ;
              end
            end
            CMD_PEEK_BACK: begin
              if (is_empty_q) begin
                load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = slot_of(front_r, occ_m1_lo);
                state_nxt = ST_READ;
              end
            end
            CMD_READ_INDEX: begin
              if (!pos_ok) begin
                load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = slot_of(front_r, pos_lo);
                state_nxt = ST_READ;
              end
            end
            CMD_ERASE: begin
              // result goes out now; the gap is closed behind it
              load    = 1'b1;
              load_ok = pos_ok;
              if (pos_ok) begin
                occ_nxt   = occ_m1;
                k_nxt     = pos_lo;
                state_nxt = ST_SHIFT_RD;
              end
            end
            CMD_CLEAR: begin
              load      = 1'b1;
              load_ok   = 1'b1;
              front_nxt = '0;
              occ_nxt   = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load         = 1'b1;
        load_ok      = 1'b1;
        load_payload = rd_word[31:0];
        state_nxt    = ST_IDLE;
      end
      ST_SHIFT_RD: begin
        // occ_r already holds the count after erase
        if (CW'(k_r) < occ_r) begin
          rd_en     = 1'b1;
          rd_addr   = slot_of(front_r, k_inc);
          state_nxt = ST_SHIFT_WR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = slot_of(front_r, k_r);
        k_nxt     = k_inc;
        state_nxt = ST_SHIFT_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register
  assign cnt_word = {5'd0, occ_nxt};

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_nxt.payload_out = load_payload;
      out_nxt.succeeded   = load_ok;
      out_nxt.entry_count = cnt_word[4:0];
      out_nxt.is_empty    = (occ_nxt == '0);
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* dv/tb_indexed_double_ended_queue.sv */
module tb_indexed_double_ended_queue;
  import idq_pkg::*;

  localparam int RING_DEPTH    = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_PRINTED   = 40;

  // Highest operation code; not decoded by the block
  localparam logic [3:0] OP_UNDEFINED_TOP = 4'hF;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  idq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  idq_out_t out_data;

  // Shadow deque state
  logic [31:0] ring_words [RING_DEPTH];
  logic [3:0]  ring_head = '0;
  int unsigned held      = 0;

  idq_out_t    awaited_results [$];
  idq_out_t    next_expected;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;

  // Idle knobs and receiver hold-off bookkeeping
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  int unsigned hold_seq    = 0;
  int unsigned hold_seen   = 0;
  int unsigned stall_left  = 0;

  indexed_double_ended_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] ring_slot(int unsigned offset);
    return ring_head + offset[3:0];
  endfunction

  // Apply one request to the shadow deque and return the beat it should produce
  function automatic idq_out_t apply_deque_op(idq_in_t req);
    idq_out_t    res;
    int unsigned k;
    res = '0;
    case (req.operation)
      OP_PUSH_FRONT: begin
        if (held < RING_DEPTH) begin
          ring_head = ring_head - 4'd1;
          ring_words[ring_head] = req.payload_in;
          held++;
          res.succeeded = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (held < RING_DEPTH) begin
          ring_words[ring_slot(held)] = req.payload_in;
          held++;
          res.succeeded = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held > 0) begin
          res.payload_out = ring_words[ring_head];
          ring_head = ring_head + 4'd1;
          held--;
          res.succeeded = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (held > 0) begin
          res.payload_out = ring_words[ring_slot(held - 1)];
          held--;
          res.succeeded = 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (held > 0) begin
          res.payload_out = ring_words[ring_head];
          res.succeeded = 1'b1;
        end
      end
      OP_PEEK_BACK: begin
        if (held > 0) begin
          res.payload_out = ring_words[ring_slot(held - 1)];
          res.succeeded = 1'b1;
        end
      end
      OP_READ_INDEX: begin
        if (req.position < held) begin
          res.payload_out = ring_words[ring_slot(req.position)];
          res.succeeded = 1'b1;
        end
      end
      OP_ERASE: begin
        // later entries slide one place toward the front
        if (req.position < held) begin
          for (k = req.position; k + 1 < held; k++)
            ring_words[ring_slot(k)] = ring_words[ring_slot(k + 1)];
          held--;
          res.succeeded = 1'b1;
        end
      end
      OP_CLEAR: begin
        ring_head = '0;
        held = 0;
        res.succeeded = 1'b1;
      end
      default: begin
      end
    endcase
    res.entry_count = held[4:0];
    res.is_empty    = (held == 0);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic idq_in_t make_request(int unsigned push_pct);
    idq_in_t     req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < push_pct) begin
      req.operation = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (pick < 14) begin
      req.operation = OP_POP_FRONT;
    end else if (pick < 28) begin
      req.operation = OP_POP_BACK;
    end else if (pick < 38) begin
      req.operation = OP_PEEK_FRONT;
    end else if (pick < 48) begin
      req.operation = OP_PEEK_BACK;
    end else if (pick < 68) begin
      req.operation = OP_READ_INDEX;
    end else if (pick < 88) begin
      req.operation = OP_ERASE;
    end else if (pick < 93) begin
      req.operation = OP_CLEAR;
    end else begin
      req.operation = 4'($urandom_range(9, 15));
    end
    // positions mostly land inside the current count
    if (held > 0 && $urandom_range(0, 3) != 0)
      req.position = 4'($urandom_range(0, held - 1));
    else
      req.position = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick == 0)
      req.payload_in = '0;
    else if (pick == 1)
      req.payload_in = '1;
    else
      req.payload_in = $urandom;
    return req;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("[%0d] mismatch: %s", cycle_count, what);
  endtask

  // Offer one request beat, hold it until accepted, then predict its result
  task automatic send_req(idq_in_t req);
    int unsigned gap;
    idq_out_t    predicted;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 99) < 30) gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = apply_deque_op(req);
    awaited_results = {awaited_results, predicted};
  endtask

  task automatic send_op(logic [3:0] op, logic [31:0] payload, logic [3:0] pos);
    idq_in_t req;
    req.operation  = op;
    req.payload_in = payload;
    req.position   = pos;
    send_req(req);
  endtask

  task automatic run_random(int unsigned count, int unsigned push_pct);
    repeat (count) send_req(make_request(push_pct));
  endtask

  task automatic wait_all_results();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Every access refused on an empty queue; clear still succeeds
  task automatic test_empty_queue();
    send_op(OP_POP_FRONT, 32'h1, 4'd0);
    send_op(OP_POP_BACK, 32'h1, 4'd0);
    send_op(OP_PEEK_FRONT, 32'h1, 4'd0);
    send_op(OP_PEEK_BACK, 32'h1, 4'd0);
    send_op(OP_READ_INDEX, 32'h1, 4'd0);
    send_op(OP_ERASE, 32'h1, 4'd0);
    send_op(OP_CLEAR, 32'h1, 4'd0);
    send_op(OP_UNDEFINED_TOP, 32'hFFFF_FFFF, 4'd15);
  endtask

  // Fill from both ends, refuse pushes when full, then touch the last index
  task automatic test_full_queue();
    int i;
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
    send_op(OP_PUSH_BACK, 32'h0, 4'd0);
    for (i = 2; i < RING_DEPTH; i++)
      send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, 4'd0);
    send_op(OP_PUSH_FRONT, $urandom, 4'd0);
    send_op(OP_PUSH_BACK, $urandom, 4'd0);
    send_op(OP_READ_INDEX, 32'h0, 4'd15);
    // longest erase: every later entry moves
    send_op(OP_ERASE, 32'h0, 4'd0);
  endtask

  task automatic test_random_mix();
    run_random(850, 50);
  endtask

  // Alternate push-heavy and drain-heavy bursts so full and empty both recur
  task automatic test_fill_and_drain();
    repeat (8) begin
      run_random(30, 85);
      run_random(30, 15);
    end
  endtask

  // Receiver stalls a long stretch while requests keep coming
  task automatic test_receiver_hold();
    tx_idle_on = 1'b0;
    hold_seq <= hold_seq + 1;
    run_random(40, 60);
    // the last beat was taken; stop offering while the results drain
    in_valid <= 1'b0;
    wait_all_results();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    run_random(300, 55);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // Result receiver: random stalls plus an on-demand long hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  = hold_seq;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", out_data));
      end else begin
        next_expected = awaited_results[0];
        awaited_results.delete(0);
        if (out_data.payload_out !== next_expected.payload_out)
          report_mismatch($sformatf("payload_out %h, expected %h",
                                    out_data.payload_out, next_expected.payload_out));
        if (out_data.succeeded !== next_expected.succeeded)
          report_mismatch($sformatf("succeeded %b, expected %b",
                                    out_data.succeeded, next_expected.succeeded));
        if (out_data.entry_count !== next_expected.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    out_data.entry_count, next_expected.entry_count));
        if (out_data.is_empty !== next_expected.is_empty)
          report_mismatch($sformatf("is_empty %b, expected %b",
                                    out_data.is_empty, next_expected.is_empty));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_full_queue();
    test_random_mix();
    test_fill_and_drain();
    test_receiver_hold();
    test_back_to_back();

    in_valid <= 1'b0;
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
